@@ rtl/text_cell_console_writer_macros.svh @@
// Assertion helpers for the text cell console writer.
`ifndef TEXT_CELL_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CELL_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TCCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tccw assertion failed");

// Next-cycle implication, disabled during reset.
`define TCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tccw assertion failed");

`endif

@@ rtl/tccw_pkg.sv @@
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int CELL_W  = 32;
    localparam int CODE_W  = 16;
    localparam int COLOR_W = 16;
    localparam int FUNC_W  = 3;
    localparam int ROWA_W  = 5;
    localparam int COLA_W  = 6;
    localparam int CURX_W  = 6;
    localparam int CURY_W  = 5;
    localparam int CFGC_W  = 7;
    localparam int CFGR_W  = 6;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [CODE_W-1:0] CODE_NEWLINE = 16'd10;
    localparam logic [CODE_W-1:0] CODE_SPACE   = 16'd32;
    localparam logic [CODE_W-1:0] CODE_DEL     = 16'd127;

    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUT    = 3'd0,
        FN_SCROLL = 3'd1,
        FN_CLEAR  = 3'd2,
        FN_FILL   = 3'd3,
        FN_READ   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        SEL_WALK   = 2'd0,
        SEL_DST    = 2'd1,
        SEL_CURSOR = 2'd2
    } agu_sel_t;

    typedef struct packed {
        agu_sel_t sel;
        logic     full;
    } agu_ctrl_t;

    typedef struct packed {
        logic x_last;
        logic y_last;
    } agu_stat_t;

endpackage

@@ rtl/text_cell_console_writer.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Handshake             Payload
// s_       in   s_valid / s_ready     s_func s_code_point s_cell_color s_row_arg s_column_arg
// m_       out  m_valid / m_ready     m_cursor_column m_cursor_row m_read_code m_read_color
// APB      in   psel penable pwrite   paddr pwdata prdata (pready tied high)
//
// Put character, unused codes, and clear, scroll or read off screen: straight to S_FIN.
// Read cell: S_RD. Clear line: S_CLR. Fill: S_FILL. Scroll by n: S_SCR_RD then S_SCR_WR.
// All walks go through one address unit and the single port of the cell RAM.
// After reset the RAM is zeroed in S_INIT, with s_ready low.
// One item in flight; a held result stalls the next item only in its final state, S_FIN.

`include "text_cell_console_writer_macros.svh"

module text_cell_console_writer
    import tccw_pkg::*;
#(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [CODE_W-1:0]   s_code_point,
    input  logic [COLOR_W-1:0]  s_cell_color,
    input  logic [ROWA_W-1:0]   s_row_arg,
    input  logic [COLA_W-1:0]   s_column_arg,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CURX_W-1:0]   m_cursor_column,
    output logic [CURY_W-1:0]   m_cursor_row,
    output logic [CODE_W-1:0]   m_read_code,
    output logic [COLOR_W-1:0]  m_read_color,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int XW    = $clog2(MAX_COLUMNS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_SCR_RD = 8'b0000_0100,
        S_SCR_WR = 8'b0000_1000,
        S_CLR    = 8'b0001_0000,
        S_FILL   = 8'b0010_0000,
        S_RD     = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [CFGC_W-1:0]   cols_cfg_reg;
    logic [CFGR_W-1:0]   rows_cfg_reg;
    logic [XW-1:0]       cur_x_reg, cur_x_next;
    logic [YW-1:0]       cur_y_reg, cur_y_next;
    logic [XW-1:0]       walk_x_reg, walk_x_next;
    logic [YW-1:0]       walk_y_reg, walk_y_next;
    logic [YW-1:0]       dst_y_reg, dst_y_next;
    logic [CELL_W-1:0]   fill_data_reg, fill_data_next;
    logic                rd_hit_reg, rd_hit_next;
    logic                m_valid_reg;
    logic [CURX_W-1:0]   out_col_reg;
    logic [CURY_W-1:0]   out_row_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic [COLOR_W-1:0]  out_color_reg;

    logic [CW-1:0]       cols_eff;
    logic [RW-1:0]       rows_eff;
    logic                cfg_wr;
    logic                accept;
    logic                out_free;
    func_t               func;
    logic                printable;
    logic                row_ok;
    logic                adv_x, adv_y;

    agu_ctrl_t           agu_ctrl;
    agu_stat_t           agu_stat;
    logic [AW-1:0]       ram_addr;
    logic                ram_we, ram_re;
    logic [CELL_W-1:0]   ram_wdata, ram_rdata;

    // Configuration
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROWS) ? APB_DW'(rows_cfg_reg) : APB_DW'(cols_cfg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= CFGC_W'(MAX_COLUMNS);
            rows_cfg_reg <= CFGR_W'(MAX_ROWS);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_COLS) begin
                cols_cfg_reg <= pwdata[CFGC_W-1:0];
            end else begin
                rows_cfg_reg <= pwdata[CFGR_W-1:0];
            end
        end
    end

    always_comb begin
        if (cols_cfg_reg == '0) begin
            cols_eff = CW'(1);
        end else if (int'(cols_cfg_reg) > MAX_COLUMNS) begin
            cols_eff = CW'(MAX_COLUMNS);
        end else begin
            cols_eff = CW'(cols_cfg_reg);
        end
        if (rows_cfg_reg == '0) begin
            rows_eff = RW'(1);
        end else if (int'(rows_cfg_reg) > MAX_ROWS) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = RW'(rows_cfg_reg);
        end
    end

    // Address unit and cell store
    tccw_agu #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_agu (
        .ctrl   (agu_ctrl),
        .walk_x (walk_x_reg),
        .walk_y (walk_y_reg),
        .dst_y  (dst_y_reg),
        .cur_x  (cur_x_reg),
        .cur_y  (cur_y_reg),
        .cols   (cols_eff),
        .rows   (rows_eff),
        .addr   (ram_addr),
        .stat   (agu_stat)
    );

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Sequencer
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign func      = func_t'(s_func);
    assign printable = (s_code_point >= CODE_SPACE) && (s_code_point != CODE_DEL);
    assign row_ok    = int'(s_row_arg) < int'(rows_eff);

    always_comb begin
        state_next     = state_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        walk_x_next    = walk_x_reg;
        walk_y_next    = walk_y_reg;
        dst_y_next     = dst_y_reg;
        fill_data_next = fill_data_reg;
        rd_hit_next    = rd_hit_reg;
        agu_ctrl.sel   = SEL_WALK;
        agu_ctrl.full  = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wdata      = fill_data_reg;
        adv_x          = 1'b0;
        adv_y          = 1'b0;

        case (state_reg)
            S_INIT: begin
                agu_ctrl.full = 1'b1;
                ram_we        = 1'b1;
                ram_wdata     = '0;
                adv_x         = 1'b1;
                adv_y         = agu_stat.x_last;
                if (agu_stat.x_last && agu_stat.y_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    rd_hit_next = 1'b0;
                    walk_x_next = '0;
                    dst_y_next  = '0;
                    state_next  = S_FIN;
                    case (func)
                        FN_PUT: begin
                            if (s_code_point == CODE_NEWLINE) begin
                                cur_x_next = '0;
                                if (int'(cur_y_reg) + 1 < int'(rows_eff)) begin
                                    cur_y_next = cur_y_reg + 1'b1;
                                end
                            end else if (printable) begin
                                agu_ctrl.sel = SEL_CURSOR;
                                ram_we       = 1'b1;
                                ram_wdata    = {s_code_point, s_cell_color};
                                if (int'(cur_x_reg) + 1 < int'(cols_eff)) begin
                                    cur_x_next = cur_x_reg + 1'b1;
                                end
                            end
                        end
                        FN_SCROLL: begin
                            walk_y_next = YW'(s_row_arg);
                            if (row_ok) begin
                                state_next = S_SCR_RD;
                            end
                        end
                        FN_CLEAR: begin
                            walk_y_next    = YW'(s_row_arg);
                            fill_data_next = '0;
                            if (row_ok) begin
                                state_next = S_CLR;
                            end
                        end
                        FN_FILL: begin
                            walk_y_next    = '0;
                            fill_data_next = {s_code_point, s_cell_color};
                            state_next     = S_FILL;
                        end
                        FN_READ: begin
                            walk_x_next = XW'(s_column_arg);
                            walk_y_next = YW'(s_row_arg);
                            if (row_ok && (int'(s_column_arg) < int'(cols_eff))) begin
                                rd_hit_next = 1'b1;
                                state_next  = S_RD;
                            end
                        end
                        default: begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SCR_RD: begin
                ram_re     = 1'b1;
                state_next = S_SCR_WR;
            end
            S_SCR_WR: begin
                agu_ctrl.sel = SEL_DST;
                ram_we       = 1'b1;
                ram_wdata    = ram_rdata;
                adv_x        = 1'b1;
                adv_y        = agu_stat.x_last;
                state_next   = (agu_stat.x_last && agu_stat.y_last) ? S_FIN : S_SCR_RD;
            end
            S_CLR: begin
                ram_we = 1'b1;
                adv_x  = 1'b1;
                if (agu_stat.x_last) begin
                    state_next = S_FIN;
                end
            end
            S_FILL: begin
                ram_we = 1'b1;
                adv_x  = 1'b1;
                adv_y  = agu_stat.x_last;
                if (agu_stat.x_last && agu_stat.y_last) begin
                    state_next = S_FIN;
                end
            end
            S_RD: begin
                ram_re     = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (adv_x) begin
            walk_x_next = agu_stat.x_last ? '0 : walk_x_reg + 1'b1;
        end
        if (adv_y && !agu_stat.y_last) begin
            walk_y_next = walk_y_reg + 1'b1;
            dst_y_next  = dst_y_reg + 1'b1;
        end
        if (cfg_wr) begin
            cur_x_next = '0;
            cur_y_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            walk_x_reg  <= '0;
            walk_y_reg  <= '0;
            dst_y_reg   <= '0;
            rd_hit_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            walk_x_reg  <= walk_x_next;
            walk_y_reg  <= walk_y_next;
            dst_y_reg   <= dst_y_next;
            rd_hit_reg  <= rd_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        fill_data_reg <= fill_data_next;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_FIN) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_FIN) && out_free) begin
            out_col_reg   <= CURX_W'(cur_x_reg);
            out_row_reg   <= CURY_W'(cur_y_reg);
            out_code_reg  <= rd_hit_reg ? ram_rdata[CELL_W-1:COLOR_W] : '0;
            out_color_reg <= rd_hit_reg ? ram_rdata[COLOR_W-1:0] : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cursor_column = out_col_reg;
    assign m_cursor_row    = out_row_reg;
    assign m_read_code     = out_code_reg;
    assign m_read_color    = out_color_reg;

    `TCCW_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_ready)
    `TCCW_ASSERT_NOW(a_cursor_visible, aclk, aresetn, 1'b1,
        (int'(cur_x_reg) < int'(cols_eff)) && (int'(cur_y_reg) < int'(rows_eff)))
    `TCCW_ASSERT_NOW(a_write_in_store, aclk, aresetn, ram_we, int'(ram_addr) < DEPTH)
    `TCCW_ASSERT_NEXT(a_fin_gives_result, aclk, aresetn,
        (state_reg == S_FIN) && out_free, m_valid && s_ready)

endmodule

@@ rtl/tccw_ram.sv @@
`timescale 1ns / 1ps

module tccw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tccw_agu.sv @@
`timescale 1ns / 1ps

module tccw_agu
    import tccw_pkg::*;
#(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 32
) (
    input  agu_ctrl_t                                  ctrl,
    input  logic [$clog2(MAX_COLUMNS)-1:0]             walk_x,
    input  logic [$clog2(MAX_ROWS)-1:0]                walk_y,
    input  logic [$clog2(MAX_ROWS)-1:0]                dst_y,
    input  logic [$clog2(MAX_COLUMNS)-1:0]             cur_x,
    input  logic [$clog2(MAX_ROWS)-1:0]                cur_y,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]           cols,
    input  logic [$clog2(MAX_ROWS+1)-1:0]              rows,
    output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0]    addr,
    output agu_stat_t                                  stat
);

    localparam int XW = $clog2(MAX_COLUMNS);
    localparam int YW = $clog2(MAX_ROWS);
    localparam int AW = $clog2(MAX_COLUMNS * MAX_ROWS);

    logic [XW-1:0] sx;
    logic [YW-1:0] sy;
    int            lim_x;
    int            lim_y;

    always_comb begin
        case (ctrl.sel)
            SEL_WALK: begin
                sx = walk_x;
                sy = walk_y;
            end
            SEL_DST: begin
                sx = walk_x;
                sy = dst_y;
            end
            SEL_CURSOR: begin
                sx = cur_x;
                sy = cur_y;
            end
            default: begin
                sx = walk_x;
                sy = walk_y;
            end
        endcase
    end

    assign addr  = AW'(int'(sy) * MAX_COLUMNS + int'(sx));
    assign lim_x = ctrl.full ? MAX_COLUMNS : int'(cols);
    assign lim_y = ctrl.full ? MAX_ROWS : int'(rows);

    assign stat.x_last = (int'(walk_x) + 1) >= lim_x;
    assign stat.y_last = (int'(walk_y) + 1) >= lim_y;

endmodule

@@ tb/tb_text_cell_console_writer.sv @@
`timescale 1ns / 1ps

module tb_text_cell_console_writer
    import tccw_pkg::*;
();

    localparam int SCREEN_COLS   = 64;
    localparam int SCREEN_ROWS   = 32;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [APB_AW-1:0] ADDR_COLS = {REG_COLS, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_ROWS = {REG_ROWS, 2'b00};
    localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = FUNC_W'(FN_READ + 1);
    localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = '1;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [CODE_W-1:0]  code;
        logic [COLOR_W-1:0] color;
        logic [ROWA_W-1:0]  row;
        logic [COLA_W-1:0]  col;
    } screen_op_t;

    typedef struct packed {
        logic [CURX_W-1:0]  cursor_column;
        logic [CURY_W-1:0]  cursor_row;
        logic [CODE_W-1:0]  read_code;
        logic [COLOR_W-1:0] read_color;
    } screen_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func = '0;
    logic [CODE_W-1:0]   s_code_point = '0;
    logic [COLOR_W-1:0]  s_cell_color = '0;
    logic [ROWA_W-1:0]   s_row_arg = '0;
    logic [COLA_W-1:0]   s_column_arg = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CURX_W-1:0]   m_cursor_column;
    logic [CURY_W-1:0]   m_cursor_row;
    logic [CODE_W-1:0]   m_read_code;
    logic [COLOR_W-1:0]  m_read_color;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    text_cell_console_writer #(
        .MAX_COLUMNS(SCREEN_COLS),
        .MAX_ROWS   (SCREEN_ROWS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_code_point   (s_code_point),
        .s_cell_color   (s_cell_color),
        .s_row_arg      (s_row_arg),
        .s_column_arg   (s_column_arg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cursor_column(m_cursor_column),
        .m_cursor_row   (m_cursor_row),
        .m_read_code    (m_read_code),
        .m_read_color   (m_read_color),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // screen mirror
    logic [CELL_W-1:0] screen_cells [SCREEN_COLS*SCREEN_ROWS];
    logic [CFGC_W-1:0] cfg_cols = CFGC_W'(SCREEN_COLS);
    logic [CFGR_W-1:0] cfg_rows = CFGR_W'(SCREEN_ROWS);
    int                cur_x = 0;
    int                cur_y = 0;

    screen_op_t     screen_ops [$];
    screen_result_t due_results [$];
    screen_op_t     op_on_bus;
    screen_result_t got_result;
    screen_result_t want_result;
    int             send_gap = 0;
    int             stall_left = 0;
    int             errors = 0;
    bit             calm = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int visible_cols();
        if (cfg_cols == 0) return 1;
        if (cfg_cols > SCREEN_COLS) return SCREEN_COLS;
        return int'(cfg_cols);
    endfunction

    function automatic int visible_rows();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > SCREEN_ROWS) return SCREEN_ROWS;
        return int'(cfg_rows);
    endfunction

    function automatic screen_result_t apply_to_screen(input screen_op_t op);
        screen_result_t    res;
        logic [CELL_W-1:0] rd;
        logic [CELL_W-1:0] cell_word;
        int                cols;
        int                rows;
        int                n;
        cols      = visible_cols();
        rows      = visible_rows();
        n         = int'(op.row);
        rd        = '0;
        cell_word = {op.code, op.color};
        case (op.func)
            FN_PUT: begin
                if (op.code == CODE_NEWLINE) begin
                    cur_x = 0;
                    if (cur_y + 1 < rows) cur_y++;
                end else if (op.code >= CODE_SPACE && op.code != CODE_DEL) begin
                    if (cur_x < cols && cur_y < rows)
                        screen_cells[cur_y*SCREEN_COLS + cur_x] = cell_word;
                    if (cur_x + 1 < cols) cur_x++;
                end
            end
            FN_SCROLL: begin
                for (int y = n; y < rows; y++)
                    for (int x = 0; x < cols; x++)
                        screen_cells[(y-n)*SCREEN_COLS + x] = screen_cells[y*SCREEN_COLS + x];
            end
            FN_CLEAR: begin
                if (n < rows)
                    for (int x = 0; x < cols; x++) screen_cells[n*SCREEN_COLS + x] = '0;
            end
            FN_FILL: begin
                for (int y = 0; y < rows; y++)
                    for (int x = 0; x < cols; x++) screen_cells[y*SCREEN_COLS + x] = cell_word;
            end
            FN_READ: begin
                if (n < rows && op.col < cols) rd = screen_cells[n*SCREEN_COLS + op.col];
            end
            default: ;
        endcase
        res.cursor_column = cur_x[CURX_W-1:0];
        res.cursor_row    = cur_y[CURY_W-1:0];
        res.read_code     = rd[CELL_W-1:COLOR_W];
        res.read_color    = rd[COLOR_W-1:0];
        return res;
    endfunction

    function automatic screen_op_t random_op(input bit rare_heavy);
        screen_op_t op;
        int         cols;
        int         rows;
        int         pick;
        int         r;
        cols     = visible_cols();
        rows     = visible_rows();
        op.code  = CODE_W'($urandom_range(0, 16'hFFFF));
        op.color = COLOR_W'($urandom_range(0, 16'hFFFF));
        op.row   = ROWA_W'($urandom_range(0, SCREEN_ROWS - 1));
        op.col   = COLA_W'($urandom_range(0, SCREEN_COLS - 1));
        pick     = $urandom_range(0, 99);
        if (pick >= 85 && rare_heavy && $urandom_range(0, 3) != 0) pick = 70;
        if (pick < 58) begin
            op.func = FN_PUT;
            r = $urandom_range(0, 99);
            if (r < 12) op.code = CODE_NEWLINE;
            else if (r < 18) op.code = CODE_W'($urandom_range(0, CODE_SPACE - 1));
            else if (r < 21) op.code = CODE_DEL;
            else if (r < 60) op.code = CODE_W'($urandom_range(CODE_SPACE, CODE_DEL - 1));
        end else if (pick < 80) begin
            op.func = FN_READ;
            if ($urandom_range(0, 4) != 0) begin
                op.row = ROWA_W'($urandom_range(0, rows - 1));
                op.col = COLA_W'($urandom_range(0, cols - 1));
            end
        end else if (pick < 85) begin
            op.func = FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
        end else if (pick < 91) begin
            op.func = FN_CLEAR;
            if ($urandom_range(0, 4) != 0) op.row = ROWA_W'($urandom_range(0, rows - 1));
        end else if (pick < 96) begin
            op.func = FN_SCROLL;
            if ($urandom_range(0, 3) != 0) op.row = ROWA_W'($urandom_range(0, rows - 1));
        end else begin
            op.func = FN_FILL;
        end
        return op;
    endfunction

    task automatic queue_op(input logic [FUNC_W-1:0] f, input logic [CODE_W-1:0] code,
                            input logic [COLOR_W-1:0] color, input logic [ROWA_W-1:0] row,
                            input logic [COLA_W-1:0] col);
        screen_op_t op;
        op.func  = f;
        op.code  = code;
        op.color = color;
        op.row   = row;
        op.col   = col;
        screen_ops.push_back(op);
    endtask

    task automatic queue_random(input int count, input bit rare_heavy);
        for (int i = 0; i < count; i++) screen_ops.push_back(random_op(rare_heavy));
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (screen_ops.size() != 0 || s_valid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [CFGC_W-1:0] value);
        logic [APB_DW-1:0] word;
        word = $urandom;
        word[CFGC_W-1:0] = value;
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_COLS) cfg_cols = word[CFGC_W-1:0];
        else cfg_rows = word[CFGR_W-1:0];
        cur_x = 0;
        cur_y = 0;
    endtask

    task automatic set_screen(input logic [CFGC_W-1:0] cols, input logic [CFGC_W-1:0] rows);
        wait_idle();
        reg_write(ADDR_COLS, cols);
        reg_write(ADDR_ROWS, rows);
    endtask

    // item driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) due_results.push_back(apply_to_screen(op_on_bus));
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (screen_ops.size() > 0) begin
                op_on_bus = screen_ops.pop_front();
                s_func       <= op_on_bus.func;
                s_code_point <= op_on_bus.code;
                s_cell_color <= op_on_bus.color;
                s_row_arg    <= op_on_bus.row;
                s_column_arg <= op_on_bus.col;
                s_valid      <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 11);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                got_result = {m_cursor_column, m_cursor_row, m_read_code, m_read_color};
                if (due_results.size() == 0) begin
                    $display("%0t: result with none due: col=%0d row=%0d code=%h color=%h",
                             $time, m_cursor_column, m_cursor_row, m_read_code, m_read_color);
                    errors++;
                end else begin
                    want_result = due_results.pop_front();
                    if (got_result !== want_result) begin
                        $display("%0t: mismatch expected col=%0d row=%0d code=%h color=%h",
                                 $time, want_result.cursor_column, want_result.cursor_row,
                                 want_result.read_code, want_result.read_color);
                        $display("%0t:          actual   col=%0d row=%0d code=%h color=%h",
                                 $time, got_result.cursor_column, got_result.cursor_row,
                                 got_result.read_code, got_result.read_color);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        for (int i = 0; i < SCREEN_COLS*SCREEN_ROWS; i++) screen_cells[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // full-size screen
        queue_op(FN_READ, 16'h0000, 16'h0000, 0, 0);
        queue_op(FN_PUT, 16'h0041, 16'hFFFF, 31, 63);
        queue_op(FN_PUT, 16'hFFFF, 16'h0000, 0, 0);
        queue_op(FN_PUT, CODE_SPACE, 16'h5A5A, 0, 0);
        queue_op(FN_PUT, CODE_NEWLINE, 16'h0000, 0, 0);
        queue_op(FN_PUT, 16'h0000, 16'hFFFF, 0, 0);
        queue_op(FN_PUT, 16'h001F, 16'hFFFF, 0, 0);
        queue_op(FN_PUT, CODE_DEL, 16'hFFFF, 0, 0);
        queue_op(FN_PUT, 16'h0080, 16'h1234, 0, 0);
        queue_op(FN_READ, 16'hFFFF, 16'hFFFF, 0, 1);
        queue_op(FN_READ, 16'h0000, 16'h0000, 1, 0);
        queue_op(FN_READ, 16'h0000, 16'h0000, 1, 1);
        queue_op(FN_SCROLL, 16'h0000, 16'h0000, 1, 0);
        queue_op(FN_READ, 16'h0000, 16'h0000, 0, 0);
        queue_op(FN_CLEAR, 16'h0000, 16'h0000, 0, 0);
        queue_op(FN_FILL, 16'hFFFF, 16'hFFFF, 0, 0);
        queue_op(FN_CLEAR, 16'h0000, 16'h0000, 31, 0);
        queue_op(FN_SCROLL, 16'h0000, 16'h0000, 31, 0);
        queue_op(FN_READ, 16'h0000, 16'h0000, 0, 63);
        queue_op(FN_READ, 16'h0000, 16'h0000, 30, 63);
        queue_op(FN_SCROLL, 16'h0000, 16'h0000, 0, 0);
        queue_op(FN_SPARE_FIRST, 16'hFFFF, 16'hFFFF, 31, 63);
        queue_op(FN_SPARE_LAST, 16'h0041, 16'h0001, 0, 0);

        // zero registers clamp to a single cell
        set_screen(0, 0);
        queue_op(FN_PUT, 16'h0078, 16'hC3C3, 0, 0);
        queue_op(FN_PUT, CODE_NEWLINE, 16'h0000, 0, 0);
        queue_op(FN_READ, 16'h0000, 16'h0000, 0, 1);
        queue_op(FN_CLEAR, 16'h0000, 16'h0000, 1, 0);
        queue_op(FN_SCROLL, 16'h0000, 16'h0000, 1, 0);
        queue_op(FN_READ, 16'h0000, 16'h0000, 0, 0);
        queue_random(100, 1'b0);

        // oversized registers clamp to the maximum
        set_screen(7'h7F, 7'h3F);
        queue_random(100, 1'b1);

        set_screen(CFGC_W'($urandom_range(1, 16)), CFGC_W'($urandom_range(1, 8)));
        queue_random(100, 1'b0);

        set_screen(CFGC_W'(SCREEN_COLS), CFGC_W'(SCREEN_ROWS));
        queue_random(50, 1'b1);
        wait_idle();
        queue_random(50, 1'b1);

        set_screen(CFGC_W'($urandom_range(1, 24)), CFGC_W'($urandom_range(1, 12)));
        queue_random(100, 1'b0);

        set_screen(CFGC_W'($urandom_range(1, 12)), CFGC_W'($urandom_range(1, 6)));
        calm = 1'b1;
        queue_random(100, 1'b0);

        wait_idle();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tccw_pkg.sv
rtl/tccw_ram.sv
rtl/tccw_agu.sv
rtl/text_cell_console_writer.sv
tb/tb_text_cell_console_writer.sv
